// ===== hdl/raised_cosine_onset_taper_unit_assert.svh =====
// Assertion macros shared by the taper unit RTL.
// Expects clk_i and rst_ni in the including module's scope.
`ifndef RAISED_COSINE_ONSET_TAPER_UNIT_ASSERT_SVH
`define RAISED_COSINE_ONSET_TAPER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset.
`define RCOT_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rcot assertion failed");

// Checked at every edge, reset included.
`define RCOT_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("rcot reset assertion failed");

`else

`define RCOT_ASSERT(name, prop)
`define RCOT_ASSERT_RST(name, prop)

`endif

`endif

// ===== hdl/rcot_pkg.sv =====
// Shared types and constants for the raised-cosine onset taper unit.
// No dependencies; used by every module in this folder by scoped name.
package rcot_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAPER_SAMPLES = 2'd0,
    REG_LEVEL_OFFSET  = 2'd1
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_MUL_T,
    ST_MUL_T2,
    ST_HMUL,
    ST_HDIV,
    ST_MUL_S,
    ST_MUL_W,
    ST_SCALE,
    ST_FINISH
  } seq_state_e;

  // Handshake status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // Fixed-point word of the sine evaluation (Q1.30 / Q2.30 values)
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned Q30_SHIFT = 30;
  localparam int unsigned DIGIT_W   = 4;

  localparam logic [WORD_W-1:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [30:0]       Q30_ONE     = 31'h4000_0000;

  // Horner divisors of the sine series, innermost term first
  localparam int unsigned HORNER_TERMS = 5;
  localparam int unsigned HORNER_IDX_W = 3;
  localparam int unsigned HDIV_W       = 7;
  localparam logic [HORNER_IDX_W-1:0] HORNER_LAST = 3'd4;
  localparam logic [HDIV_W-1:0] HORNER_DIV [0:HORNER_TERMS-1] =
    '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};

endpackage

// ===== hdl/raised_cosine_onset_taper_unit.sv =====
// Top level of the raised-cosine onset taper: sequencer, config and output stage.
// Uses rcot_pkg, rcot_pdiv, rcot_mul, rcot_cdiv and the assertion macro header.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    sample_in_i, block_end_in_i
//   out      source     out_valid_o / out_stall_i  sample_out_o, block_end_out_o
//   cfg      sink       cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One transaction at a time. Past the ramp (or with zero length) a sample goes straight
// to the result state. Inside the ramp: phase division, then ten multiplies and five
// constant divides on the digit-serial units, and a final state that loads the result.
// The output register frees the input side: a new transaction is taken while a result
// waits under out_stall_i. Reset clears both registers and the ramp position.
`include "raised_cosine_onset_taper_unit_assert.svh"

module raised_cosine_onset_taper_unit #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH  = 16,
  parameter int unsigned PHASE_BITS   = 10,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]          sample_in_i,
  input  logic                                    block_end_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]          sample_out_o,
  output logic                                    block_end_out_o,
  input  logic                                    cfg_we_i,
  input  logic [rcot_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [(SAMPLE_WIDTH > COUNT_WIDTH ? SAMPLE_WIDTH : COUNT_WIDTH)-1:0] cfg_wdata_i
);

  localparam int unsigned WordW   = rcot_pkg::WORD_W;
  localparam int unsigned Q30     = rcot_pkg::Q30_SHIFT;
  localparam int unsigned MulAw   = (SAMPLE_WIDTH > WordW) ? SAMPLE_WIDTH : WordW;
  localparam int unsigned MulBw   = WordW;
  localparam int unsigned ProdW   = MulAw + MulBw;
  localparam int unsigned SqW     = 2 * WordW;
  localparam int unsigned WrawW   = WEIGHT_BITS + 4;
  localparam int unsigned WeightW = WEIGHT_BITS + 1;
  localparam logic [SqW-1:0]   WRound = SqW'(1) << (59 - WEIGHT_BITS);
  localparam logic [WrawW-1:0] WMax   = WrawW'(1) << WEIGHT_BITS;

  rcot_pkg::seq_state_e state_q, state_d;

  logic [COUNT_WIDTH-1:0]  n_q, n_d;
  logic [SAMPLE_WIDTH-1:0] off_q, off_d;
  logic [COUNT_WIDTH-1:0]  pos_q, pos_d;

  logic [SAMPLE_WIDTH-1:0] mag_q, mag_d;
  logic                    neg_q, neg_d;
  logic                    end_q, end_d;
  logic [MulAw-1:0]        op_a_q, op_a_d;
  logic [MulBw-1:0]        op_b_q, op_b_d;
  logic [WordW-1:0]        t_q, t_d;
  logic [WordW-1:0]        t2_q, t2_d;
  logic [WordW-1:0]        div_x_q, div_x_d;
  logic [rcot_pkg::HORNER_IDX_W-1:0] hidx_q, hidx_d;
  logic [SAMPLE_WIDTH-1:0] y_q, y_d;
  logic                    mul_go_q, mul_go_d;
  logic                    cdiv_go_q, cdiv_go_d;

  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0] sample_out_q, sample_out_d;
  logic                    end_out_q, end_out_d;

  logic                    in_accept;
  logic                    out_take;
  logic                    active;
  logic                    cfg_clear;
  logic                    pdiv_go;
  logic                    out_load;
  logic                    in_neg;

  rcot_pkg::unit_sts_t     pdiv_sts, mul_sts, cdiv_sts;
  logic [PHASE_BITS-1:0]   phase;
  logic [ProdW-1:0]        prod;
  logic [WordW-1:0]        quot;
  logic [30:0]             u_next;
  logic [SqW-1:0]          wsum;
  logic [WrawW-1:0]        wraw;
  logic [WeightW-1:0]      weight;
  logic [SAMPLE_WIDTH-1:0] scaled;

  assign in_stall_o = (state_q != rcot_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign active     = (pos_q < n_q);
  assign in_neg     = ($signed(sample_in_i) < $signed(off_q));

  // ---- configuration registers and ramp position
  always_comb begin
    n_d       = n_q;
    off_d     = off_q;
    cfg_clear = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcot_pkg::REG_TAPER_SAMPLES: begin
          n_d       = cfg_wdata_i[COUNT_WIDTH-1:0];
          cfg_clear = 1'b1;
        end
        rcot_pkg::REG_LEVEL_OFFSET: begin
          off_d     = cfg_wdata_i[SAMPLE_WIDTH-1:0];
          cfg_clear = 1'b1;
        end
        default: ;
      endcase
    end
    priority if (cfg_clear)            pos_d = '0;
    else if (in_accept && active)      pos_d = pos_q + COUNT_WIDTH'(1);
    else                               pos_d = pos_q;
  end

  // ---- weight from sin^2: round, then saturate at one
  always_comb begin
    wsum   = prod[SqW-1:0] + WRound;
    wraw   = wsum[SqW-1:60-WEIGHT_BITS];
    weight = (wraw > WMax) ? WMax[WeightW-1:0] : wraw[WeightW-1:0];
    u_next = rcot_pkg::Q30_ONE - quot[30:0];
    scaled = prod[WEIGHT_BITS +: SAMPLE_WIDTH];
  end

  // ---- sequencer
  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    end_d     = end_q;
    op_a_d    = op_a_q;
    op_b_d    = op_b_q;
    t_d       = t_q;
    t2_d      = t2_q;
    div_x_d   = div_x_q;
    hidx_d    = hidx_q;
    y_d       = y_q;
    mul_go_d  = 1'b0;
    cdiv_go_d = 1'b0;
    pdiv_go   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      rcot_pkg::ST_IDLE: begin
        if (in_accept) begin
          end_d = block_end_in_i;
          neg_d = in_neg;
          mag_d = in_neg ? (off_q - sample_in_i) : (sample_in_i - off_q);
          if (active) begin
            pdiv_go = 1'b1;
            state_d = rcot_pkg::ST_PHASE;
          end else begin
            y_d     = sample_in_i;
            state_d = rcot_pkg::ST_FINISH;
          end
        end
      end
      rcot_pkg::ST_PHASE: begin
        if (pdiv_sts.done) begin
          op_a_d   = MulAw'(rcot_pkg::HALF_PI_Q30);
          op_b_d   = MulBw'(phase);
          mul_go_d = 1'b1;
          state_d  = rcot_pkg::ST_MUL_T;
        end
      end
      rcot_pkg::ST_MUL_T: begin
        if (mul_sts.done) begin
          t_d      = prod[PHASE_BITS +: WordW];
          op_a_d   = MulAw'(prod[PHASE_BITS +: WordW]);
          op_b_d   = prod[PHASE_BITS +: WordW];
          mul_go_d = 1'b1;
          state_d  = rcot_pkg::ST_MUL_T2;
        end
      end
      rcot_pkg::ST_MUL_T2: begin
        if (mul_sts.done) begin
          t2_d     = prod[Q30 +: WordW];
          op_a_d   = MulAw'(rcot_pkg::Q30_ONE);
          op_b_d   = prod[Q30 +: WordW];
          hidx_d   = '0;
          mul_go_d = 1'b1;
          state_d  = rcot_pkg::ST_HMUL;
        end
      end
      rcot_pkg::ST_HMUL: begin
        if (mul_sts.done) begin
          div_x_d   = prod[Q30 +: WordW];
          cdiv_go_d = 1'b1;
          state_d   = rcot_pkg::ST_HDIV;
        end
      end
      rcot_pkg::ST_HDIV: begin
        if (cdiv_sts.done) begin
          op_a_d   = MulAw'(u_next);
          mul_go_d = 1'b1;
          if (hidx_q == rcot_pkg::HORNER_LAST) begin
            op_b_d  = t_q;
            state_d = rcot_pkg::ST_MUL_S;
          end else begin
            op_b_d  = t2_q;
            hidx_d  = hidx_q + rcot_pkg::HORNER_IDX_W'(1);
            state_d = rcot_pkg::ST_HMUL;
          end
        end
      end
      rcot_pkg::ST_MUL_S: begin
        if (mul_sts.done) begin
          op_a_d   = MulAw'(prod[Q30 +: WordW]);
          op_b_d   = prod[Q30 +: WordW];
          mul_go_d = 1'b1;
          state_d  = rcot_pkg::ST_MUL_W;
        end
      end
      rcot_pkg::ST_MUL_W: begin
        if (mul_sts.done) begin
          op_a_d   = MulAw'(mag_q);
          op_b_d   = MulBw'(weight);
          mul_go_d = 1'b1;
          state_d  = rcot_pkg::ST_SCALE;
        end
      end
      rcot_pkg::ST_SCALE: begin
        if (mul_sts.done) begin
          // magnitude truncated, so the step toward the offset rounds toward it
          y_d     = neg_q ? (off_q - scaled) : (off_q + scaled);
          state_d = rcot_pkg::ST_FINISH;
        end
      end
      rcot_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = rcot_pkg::ST_IDLE;
        end
      end
      default: state_d = rcot_pkg::ST_IDLE;
    endcase
  end

  // ---- output register
  always_comb begin
    out_valid_d  = out_valid_q;
    sample_out_d = sample_out_q;
    end_out_d    = end_out_q;
    priority if (out_load) begin
      out_valid_d  = 1'b1;
      sample_out_d = y_q;
      end_out_d    = end_q;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcot_pkg::ST_IDLE;
      n_q         <= '0;
      off_q       <= '0;
      pos_q       <= '0;
      mul_go_q    <= 1'b0;
      cdiv_go_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      off_q       <= off_d;
      pos_q       <= pos_d;
      mul_go_q    <= mul_go_d;
      cdiv_go_q   <= cdiv_go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q        <= mag_d;
    neg_q        <= neg_d;
    end_q        <= end_d;
    op_a_q       <= op_a_d;
    op_b_q       <= op_b_d;
    t_q          <= t_d;
    t2_q         <= t2_d;
    div_x_q      <= div_x_d;
    hidx_q       <= hidx_d;
    y_q          <= y_d;
    sample_out_q <= sample_out_d;
    end_out_q    <= end_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = sample_out_q;
  assign block_end_out_o = end_out_q;

  // ---- serial arithmetic units
  rcot_pdiv #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .PHASE_BITS  (PHASE_BITS)
  ) u_pdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pdiv_go),
    .k_i     (pos_q),
    .n_i     (n_q),
    .sts_o   (pdiv_sts),
    .phase_o (phase)
  );

  rcot_mul #(
    .AW (MulAw),
    .BW (MulBw)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (op_a_q),
    .b_i     (op_b_q),
    .sts_o   (mul_sts),
    .prod_o  (prod)
  );

  rcot_cdiv u_cdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cdiv_go_q),
    .x_i     (div_x_q),
    .div_i   (rcot_pkg::HORNER_DIV[hidx_q]),
    .sts_o   (cdiv_sts),
    .quot_o  (quot)
  );

  // ---- assertions
  `RCOT_ASSERT(pos_in_range_a, pos_q <= n_q)
  `RCOT_ASSERT(units_exclusive_a, !(mul_sts.busy && cdiv_sts.busy))
  `RCOT_ASSERT(bypass_to_finish_a, (in_accept && !active) |=> (state_q == rcot_pkg::ST_FINISH))
  `RCOT_ASSERT(weight_bounded_a, (state_q == rcot_pkg::ST_SCALE) |-> (op_b_q <= MulBw'(WMax)))
  `RCOT_ASSERT_RST(quiet_out_of_reset_a, $rose(rst_ni) |-> (!out_valid_q && !mul_sts.busy))

endmodule

// ===== hdl/rcot_pdiv.sv =====
// Bit-serial restoring divider for the ramp phase floor(k * 2^PHASE_BITS / n).
// Requires k < n. Depends on rcot_pkg.
module rcot_pdiv #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned PHASE_BITS  = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [COUNT_WIDTH-1:0]  k_i,
  input  logic [COUNT_WIDTH-1:0]  n_i,
  output rcot_pkg::unit_sts_t     sts_o,
  output logic [PHASE_BITS-1:0]   phase_o
);

  localparam int unsigned CntW = $clog2(PHASE_BITS + 1);

  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [COUNT_WIDTH-1:0] n_q, n_d;
  logic [PHASE_BITS-1:0]  quo_q, quo_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;

  logic [COUNT_WIDTH:0]   rem2;
  logic                   fits;

  always_comb begin
    rem2   = {rem_q, 1'b0};
    fits   = (rem2 >= {1'b0, n_q});
    rem_d  = rem_q;
    n_d    = n_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = k_i;
      n_d    = n_i;
      cnt_d  = CntW'(PHASE_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? COUNT_WIDTH'(rem2 - {1'b0, n_q}) : rem2[COUNT_WIDTH-1:0];
      quo_d = {quo_q[PHASE_BITS-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    n_q   <= n_d;
    quo_q <= quo_d;
  end

  assign sts_o   = '{busy: busy_q, done: done_q};
  assign phase_o = quo_q;

endmodule

// ===== hdl/rcot_mul.sv =====
// Digit-serial unsigned multiplier, one multiplier digit per cycle.
// Product shifts in from the top; depends on rcot_pkg for the digit width.
module rcot_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [AW-1:0]        a_i,
  input  logic [BW-1:0]        b_i,
  output rcot_pkg::unit_sts_t  sts_o,
  output logic [AW+BW-1:0]     prod_o
);

  localparam int unsigned DigitW = rcot_pkg::DIGIT_W;
  localparam int unsigned Digits = BW / DigitW;
  localparam int unsigned CntW   = $clog2(Digits + 1);
  localparam int unsigned PW     = AW + BW;
  localparam int unsigned SumW   = AW + DigitW;

  logic [AW-1:0]   a_q, a_d;
  logic [PW-1:0]   p_q, p_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;

  logic [DigitW-1:0] digit;
  logic [SumW-1:0]   part;
  logic [SumW-1:0]   sum;

  always_comb begin
    digit  = p_q[DigitW-1:0];
    part   = {{DigitW{1'b0}}, a_q} * {{AW{1'b0}}, digit};
    sum    = {{DigitW{1'b0}}, p_q[PW-1:BW]} + part;
    a_d    = a_q;
    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      p_d    = {{AW{1'b0}}, b_i};
      cnt_d  = CntW'(Digits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // add the digit's partial product, retire one digit of the multiplier
      p_d   = {sum, p_q[BW-1:DigitW]};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

  assign sts_o  = '{busy: busy_q, done: done_q};
  assign prod_o = p_q;

endmodule

// ===== hdl/rcot_cdiv.sv =====
// Serial divider by a small constant of the sine series, one digit per cycle.
// Dividend and quotient share one shift register; depends on rcot_pkg.
module rcot_cdiv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rcot_pkg::WORD_W-1:0]       x_i,
  input  logic [rcot_pkg::HDIV_W-1:0]       div_i,
  output rcot_pkg::unit_sts_t               sts_o,
  output logic [rcot_pkg::WORD_W-1:0]       quot_o
);

  localparam int unsigned WordW  = rcot_pkg::WORD_W;
  localparam int unsigned DigitW = rcot_pkg::DIGIT_W;
  localparam int unsigned RemW   = rcot_pkg::HDIV_W;
  localparam int unsigned Steps  = WordW / DigitW;
  localparam int unsigned CntW   = $clog2(Steps + 1);

  logic [WordW-1:0]  x_q, x_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [RemW-1:0]   div_q, div_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [DigitW-1:0] qdig;

  always_comb begin
    logic [RemW-1:0] r;
    logic [RemW:0]   r2;
    r      = rem_q;
    r2     = '0;
    qdig   = '0;
    // one restoring step per dividend bit, a digit's worth chained
    for (int j = 0; j < DigitW; j++) begin
      r2 = {r, x_q[WordW-1-j]};
      qdig[DigitW-1-j] = (r2 >= {1'b0, div_q});
      r = qdig[DigitW-1-j] ? RemW'(r2 - {1'b0, div_q}) : r2[RemW-1:0];
    end
    x_d    = x_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d    = x_i;
      rem_d  = '0;
      div_d  = div_i;
      cnt_d  = CntW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d   = {x_q[WordW-DigitW-1:0], qdig};
      rem_d = r;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign sts_o  = '{busy: busy_q, done: done_q};
  assign quot_o = x_q;

endmodule
